>>> hdl/wrsc_pkg.sv
`default_nettype none
package wrsc_pkg;

    typedef struct packed {
        logic [31:0] sample;
        logic        last;
    } wrsc_in_t;

    typedef struct packed {
        logic [10:0] ending_here;
        logic [19:0] running_total;
        logic        final_res;
        logic        overflow;
    } wrsc_out_t;

    localparam int TOTAL_BITS = 20;
    localparam int ENDING_BITS = 11;

endpackage
`default_nettype wire

>>> hdl/window_range_subarray_counter.sv
`default_nettype none
// Channel | Dir | Handshake           | Payload
// in      | in  | in_valid/in_ready   | wrsc_in_t  (sample, last)
// out     | out | out_valid/out_ready | wrsc_out_t (ending_here, running_total, ...)
// cfg     | in  | cfg_we              | cfg_data (range_limit)
// Each item is accepted and shifted into the cell chain, then counted with
// the result registered, then presented. A stalled result holds and the
// next item waits until it is taken.
// The in-range cells form a prefix; its length comes from a one-hot
// boundary folded through an OR tree.
// Reset clears all cells and counters at once; no clearing pass. After the
// last item the chain clears at the edge its result is taken.
module window_range_subarray_counter #(
    parameter int MAX_LEN = 1024,
    parameter int SAMPLE_BITS = 32
) (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               in_valid,
    output logic                    in_ready,
    input  wire wrsc_pkg::wrsc_in_t in_data,
    output logic                    out_valid,
    input  wire logic               out_ready,
    output wrsc_pkg::wrsc_out_t     out_data,
    input  wire logic               cfg_we,
    input  wire logic [31:0]        cfg_data
);
    import wrsc_pkg::*;
    localparam int PW = $clog2(MAX_LEN + 1);

    localparam logic [1:0] S_IDLE = 2'd0, S_CNT = 2'd1, S_OUT = 2'd2;

    logic [1:0]  state_reg, state_next;
    logic signed [31:0] lim_reg;
    logic [PW-1:0] pos_reg, lb_reg;
    logic [TOTAL_BITS-1:0] tot_reg, tot_next;
    logic        last_reg, ovf_reg, ovf_now, shift, clear;
    logic signed [SAMPLE_BITS-1:0] in_s;
    logic [MAX_LEN-1:0] vld, okv;
    logic [MAX_LEN:0] okx;
    logic signed [SAMPLE_BITS-1:0] mx_chain [MAX_LEN+1];
    logic signed [SAMPLE_BITS-1:0] mn_chain [MAX_LEN+1];
    logic [MAX_LEN:0] vchain;
    wrsc_out_t out_reg;
    logic [PW-1:0] left_cnt, ending;

    assign in_ready    = (state_reg == S_IDLE);
    assign ovf_now     = (pos_reg >= PW'(MAX_LEN));
    assign clear       = (state_reg == S_OUT) && out_ready && last_reg;
    assign shift       = (in_valid && in_ready && !ovf_now) || clear;
    assign in_s        = in_data.sample[SAMPLE_BITS-1:0];
    assign mx_chain[0] = in_s;
    assign mn_chain[0] = in_s;
    assign vchain[0]   = !clear;

    // chain of window cells, cell 0 holds the newest sample
    for (genvar i = 0; i < MAX_LEN; i++)
    begin : g_cell
        wrsc_cell #(.SB(SAMPLE_BITS)) u_cell (
            .clk(clk), .rst_n(rst_n), .shift(shift), .clear(clear),
            .up_valid(vchain[i]), .up_max(mx_chain[i]), .up_min(mn_chain[i]),
            .new_sample(in_s), .range_limit(lim_reg), .valid(vld[i]),
            .max_out(mx_chain[i+1]), .min_out(mn_chain[i+1]), .ok(okv[i]));
        assign vchain[i+1] = vld[i];
    end

    // in-range cells form a prefix: encode where it ends
    assign okx = {1'b0, okv};
    always_comb
    begin
        left_cnt = '0;
        for (int i = 0; i < MAX_LEN; i++)
            if (okx[i] && !okx[i+1])
                left_cnt = left_cnt | PW'(i + 1);
    end
    // left bound never moves back: at most pos - left_bound subarrays
    assign ending   = (left_cnt > (pos_reg - lb_reg)) ? (pos_reg - lb_reg) : left_cnt;
    assign tot_next = tot_reg + TOTAL_BITS'(ending);

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE: if (in_valid) state_next = S_CNT;
            S_CNT:  state_next = S_OUT;
            S_OUT:  if (out_ready) state_next = S_IDLE;
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            lim_reg   <= '0;
            pos_reg   <= '0;
            lb_reg    <= '0;
            tot_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            if (cfg_we)
                lim_reg <= $signed(cfg_data);
            if (clear)
            begin
                pos_reg <= '0; lb_reg <= '0; tot_reg <= '0;
            end
            else
            begin
                // pos_reg counts samples held
                if (in_valid && in_ready && !ovf_now)
                    pos_reg <= pos_reg + PW'(1);
                if (state_reg == S_CNT && !ovf_reg)
                begin
                    tot_reg <= tot_next;
                    lb_reg  <= pos_reg - ending;
                end
            end
        end
    end

    // capture accepted item; count stage sees the shifted chain
    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            last_reg <= in_data.last;
            ovf_reg  <= ovf_now;
        end
        if (state_reg == S_CNT)
        begin
            out_reg.final_res <= last_reg;
            out_reg.overflow  <= ovf_reg;
            if (ovf_reg)
            begin
                out_reg.ending_here   <= '0;
                out_reg.running_total <= tot_reg;
            end
            else
            begin
                out_reg.ending_here   <= ENDING_BITS'(ending);
                out_reg.running_total <= tot_next;
            end
        end
    end

    assign out_valid = (state_reg == S_OUT);
    assign out_data  = out_reg;

    a_ovf_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_data.overflow |-> out_data.ending_here == '0)
        else $error("overflow with nonzero count");
    a_rdy: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> !in_ready) else $error("ready while result pending");
    a_pos: assert property (@(posedge clk) disable iff (!rst_n)
        pos_reg <= PW'(MAX_LEN)) else $error("position past bound");
    a_lb: assert property (@(posedge clk) disable iff (!rst_n)
        lb_reg <= pos_reg) else $error("left bound past position");
endmodule
`default_nettype wire

>>> hdl/wrsc_cell.sv
`default_nettype none
// One cell of the window. Cell i stands for the sample i places behind the
// newest one. On every shift each cell takes its upstream
// neighbour's running max and min and folds in the new sample, so it holds
// the max and min of all samples from its own one to the newest.
module wrsc_cell #(
    parameter int SB = 32
) (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 shift,
    input  wire logic                 clear,
    input  wire logic                 up_valid,
    input  wire logic signed [SB-1:0] up_max,
    input  wire logic signed [SB-1:0] up_min,
    input  wire logic signed [SB-1:0] new_sample,
    input  wire logic signed [31:0]   range_limit,
    output logic                      valid,
    output logic signed [SB-1:0]      max_out,
    output logic signed [SB-1:0]      min_out,
    output logic                      ok
);
    logic                 valid_reg, valid_next;
    logic signed [SB-1:0] mx_reg, mn_reg, mx_next, mn_next;
    logic signed [SB:0]   diff;
    logic signed [32:0]   diff_x;

    // neighbour's extremes widened by the newest sample
    always_comb
    begin
        mx_next    = (new_sample > up_max) ? new_sample : up_max;
        mn_next    = (new_sample < up_min) ? new_sample : up_min;
        valid_next = clear ? 1'b0 : up_valid;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else if (shift)
            valid_reg <= valid_next;
    end

    // payload moves one cell down the chain per shift
    always_ff @(posedge clk)
    begin
        if (shift)
        begin
            mx_reg <= mx_next;
            mn_reg <= mn_next;
        end
    end

    // window from this cell to newest is within range
    assign diff    = {mx_reg[SB-1], mx_reg} - {mn_reg[SB-1], mn_reg};
    assign diff_x  = 33'(diff);
    assign valid   = valid_reg;
    assign max_out = mx_reg;
    assign min_out = mn_reg;
    assign ok      = valid_reg && !range_limit[31] && (diff_x <= 33'(range_limit));
endmodule
`default_nettype wire

>>> tb/tb.sv
module tb;
    import wrsc_pkg::*;

    localparam int SEQ_MAX = 1024;
    localparam int CYCLE_LIMIT = 400000;

    logic        clk;
    logic        rst_n;
    logic        in_valid;
    logic        in_ready;
    wrsc_in_t    in_data;
    logic        out_valid;
    logic        out_ready;
    wrsc_out_t   out_data;
    logic        cfg_we;
    logic [31:0] cfg_data;

    window_range_subarray_counter u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data),
        .cfg_we    (cfg_we),
        .cfg_data  (cfg_data)
    );

    // Window counter model with its own monotonic queues
    class window_scoreboard;
        int          mx_pos[SEQ_MAX];
        longint      mx_val[SEQ_MAX];
        int          mn_pos[SEQ_MAX];
        longint      mn_val[SEQ_MAX];
        int          mx_head, mx_tail, mn_head, mn_tail;
        int          seq_pos, left_edge;
        logic [19:0] total;
        longint      limit;
        wrsc_out_t   pending[$];
        int          errors;

        function void clear_seq();
            mx_head = 0; mx_tail = 0; mn_head = 0; mn_tail = 0;
            seq_pos = 0; left_edge = 0; total = '0;
        endfunction

        function void set_limit(logic [31:0] v);
            limit = longint'($signed(v));
        endfunction

        function void note_input(wrsc_in_t it);
            wrsc_out_t r;
            longint    s;
            int        ending;
            s = longint'($signed(it.sample));
            ending = 0;
            r = '0;
            if (seq_pos >= SEQ_MAX) begin
                r.overflow = 1'b1;
            end
            else begin
                while (mx_tail > mx_head && mx_val[mx_tail-1] <= s) mx_tail--;
                mx_pos[mx_tail] = seq_pos; mx_val[mx_tail] = s; mx_tail++;
                while (mn_tail > mn_head && mn_val[mn_tail-1] >= s) mn_tail--;
                mn_pos[mn_tail] = seq_pos; mn_val[mn_tail] = s; mn_tail++;
                if (left_edge > seq_pos) left_edge = seq_pos;
                while (mx_tail > mx_head && mn_tail > mn_head &&
                       mx_val[mx_head] - mn_val[mn_head] > limit) begin
                    left_edge++;
                    while (mx_tail > mx_head && mx_pos[mx_head] < left_edge) mx_head++;
                    while (mn_tail > mn_head && mn_pos[mn_head] < left_edge) mn_head++;
                end
                ending = seq_pos + 1 - left_edge;
                total = total + 20'(ending);
                seq_pos++;
            end
            r.ending_here = 11'(ending);
            r.running_total = total;
            r.final_res = it.last;
            pending = {pending, r};
            if (it.last) clear_seq();
        endfunction

        function void check_result(wrsc_out_t got);
            wrsc_out_t exp_r;
            if (pending.size() == 0) begin
                $error("result with nothing expected: %h", got);
                errors++;
                return;
            end
            exp_r = pending[0];
            pending.delete(0);
            if (got.ending_here !== exp_r.ending_here) begin
                $error("ending_here exp %0d got %0d", exp_r.ending_here, got.ending_here);
                errors++;
            end
            if (got.running_total !== exp_r.running_total) begin
                $error("running_total exp %0d got %0d",
                       exp_r.running_total, got.running_total);
                errors++;
            end
            if (got.final_res !== exp_r.final_res) begin
                $error("final_res exp %0b got %0b", exp_r.final_res, got.final_res);
                errors++;
            end
            if (got.overflow !== exp_r.overflow) begin
                $error("overflow exp %0b got %0b", exp_r.overflow, got.overflow);
                errors++;
            end
        endfunction
    endclass

    window_scoreboard sb;
    int cycles;
    int stall_mode;

    initial clk = 1'b0;
    always #5 clk = ~clk;

    // Watchdog
    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("tb NOT OK");
            $finish;
        end
    end

    // Receiver: stall pattern changes per phase
    always @(posedge clk)
    begin
        if (rst_n && out_valid && out_ready) sb.check_result(out_data);
        case (stall_mode)
            0: out_ready <= 1'b1;
            1: out_ready <= ($urandom_range(0, 3) != 0);
            2: out_ready <= ($urandom_range(0, 3) == 0);
            default: out_ready <= ((cycles % 7) < 4);
        endcase
    end

    // Send one item, then a random gap one time in five
    task automatic send_item(logic [31:0] s, logic l);
        in_valid <= 1'b1;
        in_data  <= '{sample: s, last: l};
        @(posedge clk);
        while (!in_ready) @(posedge clk);
        sb.note_input('{sample: s, last: l});
        if ($urandom_range(0, 4) == 0) begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge clk);
        end
    endtask

    task automatic drain_and_config(logic [31:0] v);
        in_valid <= 1'b0;
        @(posedge clk);
        while (sb.pending.size() != 0) @(posedge clk);
        repeat (10) @(posedge clk);
        cfg_we   <= 1'b1;
        cfg_data <= v;
        @(posedge clk);
        cfg_we <= 1'b0;
        sb.set_limit(v);
        stall_mode = $urandom_range(0, 3);
    endtask

    function automatic logic [31:0] rand_sample(int kind);
        case (kind)
            0: return $urandom();
            1: return 32'($signed($urandom_range(0, 20)) - 10);
            default: return $urandom_range(0, 1) ? 32'h7fffffff : 32'h80000000;
        endcase
    endfunction

    task automatic random_sequence(int len, int kind);
        for (int i = 0; i < len; i++)
            send_item(rand_sample($urandom_range(0, 9) == 0 ? 0 : kind), i == len - 1);
    endtask

    initial
    begin
        int sent;
        sb = new();
        sb.clear_seq();
        sb.set_limit(32'd0);
        sb.errors = 0;
        stall_mode = 0;
        rst_n = 1'b0;
        in_valid = 1'b0;
        in_data = '0;
        out_ready = 1'b0;
        cfg_we = 1'b0;
        cfg_data = '0;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: extremes with limit zero (reset value)
        send_item(32'h7fffffff, 1'b0);
        send_item(32'h7fffffff, 1'b0);
        send_item(32'h80000000, 1'b0);
        send_item(32'h00000000, 1'b1);
        // Full-range difference with largest limit
        drain_and_config(32'h7fffffff);
        send_item(32'h80000000, 1'b0);
        send_item(32'h7fffffff, 1'b0);
        send_item(32'hffffffff, 1'b1);
        // Negative threshold gives zero counts
        drain_and_config(32'h80000000);
        send_item(32'd5, 1'b0);
        send_item(32'd5, 1'b0);
        send_item(32'hffffffff, 1'b1);
        // Threshold changed mid-sequence
        drain_and_config(32'd3);
        send_item(32'd1, 1'b0);
        send_item(32'd4, 1'b0);
        send_item(32'd2, 1'b0);
        drain_and_config(32'd0);
        send_item(32'd2, 1'b0);
        send_item(32'd9, 1'b1);
        // Length bound: one long sequence past MAX_LEN
        drain_and_config(32'd6);
        random_sequence(SEQ_MAX + 3, 1);

        // Random sequences, mostly short
        sent = 0;
        while (sent < 900) begin
            int len;
            int k;
            if ($urandom_range(0, 5) == 0) begin
                case ($urandom_range(0, 4))
                    0: drain_and_config(32'h7fffffff);
                    1: drain_and_config(32'h80000000);
                    2: drain_and_config($urandom());
                    default: drain_and_config($urandom_range(0, 12));
                endcase
            end
            len = $urandom_range(1, 40);
            k = $urandom_range(0, 9) < 7 ? 1 : ($urandom_range(0, 1) ? 0 : 2);
            random_sequence(len, k);
            sent += len;
        end

        in_valid <= 1'b0;
        @(posedge clk);
        while (sb.pending.size() != 0) @(posedge clk);
        repeat (20) @(posedge clk);
        if (sb.errors == 0)
            $display("tb OK");
        else
            $display("tb NOT OK");
        $finish;
    end
endmodule
